@@ rtl/blm_pkg.sv @@
`default_nettype none

package blm_pkg;

   // Field and register widths
   localparam int unsigned SampleWidth   = 10;
   localparam int unsigned LevelWidth    = 3;
   localparam int unsigned CountWidth    = 8;
   localparam int unsigned LimitWidth    = 8;
   localparam int unsigned TopWidth      = 10;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 10;

   // Register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_LIMIT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TOP_LIMIT      = 2'd1;

   // Register reset values
   localparam logic [LimitWidth-1:0] DEBOUNCE_RESET = 8'd100;
   localparam logic [TopWidth-1:0]   TOP_RESET      = 10'd500;

   // Band edges of the converter reading
   localparam logic [SampleWidth-1:0] BAND_FLOOR  = 10'd200;
   localparam logic [SampleWidth-1:0] CRIT_HIGH   = 10'd345;
   localparam logic [SampleWidth-1:0] LOW_HIGH    = 10'd350;
   localparam logic [SampleWidth-1:0] LOGIN_HIGH  = 10'd355;
   localparam logic [SampleWidth-1:0] LEVEL1_HIGH = 10'd360;
   localparam logic [SampleWidth-1:0] LEVEL2_LOW  = 10'd365;
   localparam logic [SampleWidth-1:0] LEVEL2_HIGH = 10'd375;
   localparam logic [SampleWidth-1:0] LEVEL3_LOW  = 10'd380;
   localparam logic [SampleWidth-1:0] LEVEL3_HIGH = 10'd390;
   localparam logic [SampleWidth-1:0] LEVEL4_LOW  = 10'd395;
   localparam logic [SampleWidth-1:0] LEVEL4_HIGH = 10'd405;
   localparam logic [SampleWidth-1:0] LEVEL5_LOW  = 10'd410;

   localparam logic [CountWidth-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      STATUS_HEALTHY  = 2'd0,
      STATUS_LOW      = 2'd1,
      STATUS_CRITICAL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      JOB_NONE     = 2'd0,
      JOB_NORMAL   = 2'd1,
      JOB_LOW_BATT = 2'd2
   } task_type;

   typedef struct packed {
      logic [LevelWidth-1:0] level;
      logic [CountWidth-1:0] critical_count;
      logic [CountWidth-1:0] low_count;
      logic [CountWidth-1:0] login_count;
      logic                  early_low;
      status_type            status;
   } state_type;

   typedef struct packed {
      logic [LevelWidth-1:0] level;
      logic                  icon_update;
      task_type              task_request;
      status_type            battery_status;
      logic                  recovered;
      logic                  early_low_flag;
   } result_type;

   typedef struct packed {
      logic                  hit;
      logic [LevelWidth-1:0] level;
   } quant_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] value);
      sat_inc = (value == COUNT_MAX) ? COUNT_MAX : value + 1'b1;
   endfunction

   // Map a reading onto its level window; no hit inside a dead band.
   function automatic quant_type quantize(input logic [SampleWidth-1:0] sample,
                                          input logic [TopWidth-1:0]    top_limit);
      quant_type q;
      q.hit   = 1'b1;
      q.level = 3'd0;
      if (sample >= BAND_FLOOR && sample <= LOW_HIGH) begin
         q.level = 3'd0;
      end else if (sample > LOW_HIGH && sample <= LEVEL1_HIGH) begin
         q.level = 3'd1;
      end else if (sample > LEVEL2_LOW && sample <= LEVEL2_HIGH) begin
         q.level = 3'd2;
      end else if (sample > LEVEL3_LOW && sample <= LEVEL3_HIGH) begin
         q.level = 3'd3;
      end else if (sample > LEVEL4_LOW && sample <= LEVEL4_HIGH) begin
         q.level = 3'd4;
      end else if (sample > LEVEL5_LOW && sample <= top_limit) begin
         q.level = 3'd5;
      end else begin
         q.hit = 1'b0;
      end
      quantize = q;
   endfunction

endpackage

`default_nettype wire

@@ rtl/blm_req_if.sv @@
`default_nettype none

interface blm_req_if;
   logic                              valid;
   logic                              ready;
   logic [blm_pkg::SampleWidth-1:0]   adc_sample;
   logic                              login_mode;
   logic                              menu_active;

   modport source (output valid, output adc_sample, output login_mode,
                   output menu_active, input ready);
   modport sink   (input valid, input adc_sample, input login_mode,
                   input menu_active, output ready);
endinterface

`default_nettype wire

@@ rtl/blm_rsp_if.sv @@
`default_nettype none

interface blm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [blm_pkg::LevelWidth-1:0]   level;
   logic                             icon_update;
   logic [1:0]                       task_request;
   logic [1:0]                       battery_status;
   logic                             recovered;
   logic                             early_low_flag;

   modport source (output valid, output level, output icon_update, output task_request,
                   output battery_status, output recovered, output early_low_flag,
                   input ready);
   modport sink   (input valid, input level, input icon_update, input task_request,
                   input battery_status, input recovered, input early_low_flag,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/blm_core.sv @@
`default_nettype none

// Next-state and result logic for one sample.
module blm_core (
   input  var blm_pkg::state_type               state,
   input  var logic [blm_pkg::SampleWidth-1:0]  adc_sample,
   input  var logic                             login_mode,
   input  var logic                             menu_active,
   input  var logic [blm_pkg::LimitWidth-1:0]   debounce_limit,
   input  var logic [blm_pkg::TopWidth-1:0]     top_limit,
   output blm_pkg::state_type                   state_next,
   output blm_pkg::result_type                  result
);

   logic                             in_login_band;
   logic                             in_crit_band;
   logic                             in_low_band;
   logic                             drawn;
   logic                             recovered;
   blm_pkg::task_type                task_req;
   blm_pkg::quant_type               quant;
   logic [blm_pkg::CountWidth-1:0]   count_inc;

   assign in_login_band = adc_sample >= blm_pkg::BAND_FLOOR &&
                          adc_sample <= blm_pkg::LOGIN_HIGH;
   assign in_crit_band  = adc_sample >= blm_pkg::BAND_FLOOR &&
                          adc_sample <= blm_pkg::CRIT_HIGH;
   assign in_low_band   = adc_sample >  blm_pkg::CRIT_HIGH &&
                          adc_sample <= blm_pkg::LOW_HIGH;
   assign quant         = blm_pkg::quantize(adc_sample, top_limit);

   always_comb begin
      state_next = state;
      drawn      = 1'b0;
      recovered  = 1'b0;
      task_req   = blm_pkg::JOB_NONE;
      count_inc  = '0;
      priority if (login_mode) begin
         if (in_login_band) begin
            count_inc              = blm_pkg::sat_inc(state.login_count);
            state_next.login_count = count_inc;
            if (count_inc > debounce_limit) begin
               state_next.early_low = 1'b1;
            end
         end else begin
            state_next.login_count = '0;
         end
         drawn = quant.hit;
         if (quant.hit) begin
            state_next.level = quant.level;
         end
      end else if (in_crit_band) begin
         count_inc                 = blm_pkg::sat_inc(state.critical_count);
         state_next.critical_count = count_inc;
         if (count_inc >= debounce_limit) begin
            drawn                     = 1'b1;
            task_req                  = blm_pkg::JOB_LOW_BATT;
            state_next.status         = blm_pkg::STATUS_CRITICAL;
            state_next.critical_count = '0;
         end
      end else if (in_low_band) begin
         count_inc            = blm_pkg::sat_inc(state.low_count);
         state_next.low_count = count_inc;
         if (count_inc >= debounce_limit) begin
            drawn                = 1'b1;
            task_req             = blm_pkg::JOB_NORMAL;
            state_next.level     = '0;
            state_next.status    = blm_pkg::STATUS_LOW;
            state_next.low_count = '0;
         end
      end else begin
         task_req = blm_pkg::JOB_NORMAL;
         drawn    = quant.hit;
         if (quant.hit) begin
            state_next.level = quant.level;
         end
         if (state.status == blm_pkg::STATUS_CRITICAL) begin
            state_next.status = blm_pkg::STATUS_HEALTHY;
            recovered         = 1'b1;
         end
      end
   end

   always_comb begin
      result.level          = state_next.level;
      result.icon_update    = drawn && !menu_active;
      result.task_request   = task_req;
      result.battery_status = state_next.status;
      result.recovered      = recovered;
      result.early_low_flag = state_next.early_low;
   end

endmodule

`default_nettype wire

@@ rtl/battery_level_monitor.sv @@
// An accepted request is captured in the input register, then moves into the result register;
//   it waits in the input register while a stalled response still holds the result register.
// Throughput: one request per cycle unless the sink stalls; the debounce and level logic
//   is a single combinational pass between the input register and the result register.
// Reset (synchronous, active high): levels, counters, status and the early-low flag clear,
//   debounce_limit returns to 100 and top_limit to 500; both pipeline stages empty.
`default_nettype none

module battery_level_monitor (
   input  var logic                                 clock,
   input  var logic                                 reset,
   blm_req_if.sink                                  req_bus,
   blm_rsp_if.source                                rsp_bus,
   input  var logic                                 csr_we,
   input  var logic [blm_pkg::CsrIndexWidth-1:0]    csr_index,
   input  var logic [blm_pkg::CsrDataWidth-1:0]     csr_wdata
);

   // Configuration registers
   logic [blm_pkg::LimitWidth-1:0]  debounce_ff;
   logic [blm_pkg::TopWidth-1:0]    top_ff;

   // Input stage
   logic                            in_valid_ff;
   logic [blm_pkg::SampleWidth-1:0] sample_ff;
   logic                            login_ff;
   logic                            menu_ff;

   // Monitor state and result stage
   blm_pkg::state_type              state_ff;
   blm_pkg::state_type              state_in;
   blm_pkg::result_type             result_in;
   blm_pkg::result_type             result_ff;
   logic                            out_valid_ff;

   logic                            advance;
   logic                            req_take;

   // Advance the input stage into the result register whenever the result
   // register is empty or being drained this cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;

   // Take a new request while the input stage is empty or moving forward.
   assign req_bus.ready = !in_valid_ff || advance;

   // Configuration writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= blm_pkg::DEBOUNCE_RESET;
         top_ff      <= blm_pkg::TOP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            blm_pkg::CSR_DEBOUNCE_LIMIT: debounce_ff <= csr_wdata[blm_pkg::LimitWidth-1:0];
            blm_pkg::CSR_TOP_LIMIT:      top_ff      <= csr_wdata[blm_pkg::TopWidth-1:0];
            default: ;
         endcase
      end
   end

   // Input register: hold the request until it moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_bus.adc_sample;
         login_ff  <= req_bus.login_mode;
         menu_ff   <= req_bus.menu_active;
      end
   end

   blm_core u_core (
      .state          (state_ff),
      .adc_sample     (sample_ff),
      .login_mode     (login_ff),
      .menu_active    (menu_ff),
      .debounce_limit (debounce_ff),
      .top_limit      (top_ff),
      .state_next     (state_in),
      .result         (result_in)
   );

   // State commits exactly once per request, in request order.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{level:          '0,
                       critical_count: '0,
                       low_count:      '0,
                       login_count:    '0,
                       early_low:      1'b0,
                       status:         blm_pkg::STATUS_HEALTHY};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: holds the response while the sink stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.level          = result_ff.level;
   assign rsp_bus.icon_update    = result_ff.icon_update;
   assign rsp_bus.task_request   = result_ff.task_request;
   assign rsp_bus.battery_status = result_ff.battery_status;
   assign rsp_bus.recovered      = result_ff.recovered;
   assign rsp_bus.early_low_flag = result_ff.early_low_flag;

   // Recovery is only reported on a normal-task sample that leaves the status healthy.
   a_recover_healthy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.recovered) |->
         (result_ff.battery_status == blm_pkg::STATUS_HEALTHY &&
          result_ff.task_request == blm_pkg::JOB_NORMAL))
      else $error("recovery reported without healthy status");

   // A low-battery task always comes with critical status.
   a_lowtask_critical: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.task_request == blm_pkg::JOB_LOW_BATT) |->
         (result_ff.battery_status == blm_pkg::STATUS_CRITICAL))
      else $error("low battery task without critical status");

   // The early-low flag is latched until reset.
   a_early_low_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(state_ff.early_low))
      else $error("early-low flag cleared outside reset");

   // Every advanced request shows up in the result register.
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request lost");

endmodule

`default_nettype wire
